[design/imu_sample_scale_and_gyro_filter_unit_assert.svh]
// Assertion macros shared by the IMU scale and gyro filter RTL.
`ifndef IMU_SAMPLE_SCALE_AND_GYRO_FILTER_UNIT_ASSERT_SVH
`define IMU_SAMPLE_SCALE_AND_GYRO_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on clk outside reset.
`define IMUSGF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define IMUSGF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/imusgf_pkg.sv]
// Package: widths, constants, control types and helpers for the IMU scale unit.
`timescale 1ns / 1ps
package imusgf_pkg;

	localparam int RawW    = 16;
	localparam int AccelW  = 14;
	localparam int RateW   = 20;
	localparam int OffW    = 13;
	localparam int CoefW   = 16;
	localparam int CfgIdxW = 3;

	// Accel product: 17-bit signed raw times 10035 fits in 30 bits
	localparam int AccelProdW = 30;
	// Gyro product: 17-bit signed raw times 999 fits in 26 bits
	localparam int GyroProdW  = 26;
	// Filter product: 17-bit coefficient times 21-bit difference
	localparam int LpProdW    = 38;

	localparam logic signed [AccelProdW-1:0] AccelGain = 30'sd10035;
	localparam logic signed [GyroProdW-1:0]  GyroGain  = 26'sd999;

	localparam logic [CoefW-1:0]       CoeffReset   = 16'd19661;
	localparam logic [CoefW-1:0]       DeadReset    = 16'd154;
	localparam logic signed [OffW-1:0] OffsetXReset = 13'sd435;
	localparam logic signed [OffW-1:0] OffsetYReset = 13'sd0;
	localparam logic signed [OffW-1:0] OffsetZReset = 13'sd205;

	typedef enum logic [CfgIdxW-1:0] {
		REG_FILTER_COEFF = 3'd0,
		REG_DEAD_ZONE    = 3'd1,
		REG_OFFSET_X     = 3'd2,
		REG_OFFSET_Y     = 3'd3,
		REG_OFFSET_Z     = 3'd4
	} cfg_reg_t;

	// Step strobes from the sequencer to every lane
	typedef struct packed {
		logic load;
		logic scale;
		logic preload;
		logic mul1;
		logic add1;
		logic mul2;
		logic done;
	} lane_ctl_t;

	// Clamp a 21-bit sum to the signed 20-bit rate range
	function automatic logic signed [RateW-1:0] sat_rate(input logic signed [RateW:0] v);
		logic signed [RateW-1:0] r;
		if (v[RateW] != v[RateW-1]) begin
			r = v[RateW] ? {1'b1, {(RateW-1){1'b0}}} : {1'b0, {(RateW-1){1'b1}}};
		end else begin
			r = v[RateW-1:0];
		end
		return r;
	endfunction

	// Sign-extend a 16-bit sample to a 17-bit lane operand
	function automatic logic signed [RawW:0] ext_raw(input logic signed [RawW-1:0] v);
		return {v[RawW-1], v};
	endfunction

endpackage

[design/imusgf_accel_lane.sv]
// One accelerometer lane: fixed-gain scaling to m/s^2 in Q8.
`timescale 1ns / 1ps
module imusgf_accel_lane (
	input  logic                                  clk,
	input  imusgf_pkg::lane_ctl_t                 ctl,
	input  logic signed [imusgf_pkg::RawW:0]      raw_in,
	output logic signed [imusgf_pkg::AccelW-1:0]  accel_out
);
	import imusgf_pkg::*;

	logic signed [AccelProdW-1:0] prod_s1;

	// Multiply on accept; hold until the next item
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			prod_s1 <= {{(AccelProdW-RawW-1){raw_in[RawW]}}, raw_in} * AccelGain;
		end
	end

	// Floor shift by 16
	assign accel_out = prod_s1[AccelProdW-1:16];

endmodule

[design/imusgf_gyro_lane.sv]
// One gyro lane: scale, offset, saturate, two low-pass stages and deadband.
`timescale 1ns / 1ps
module imusgf_gyro_lane (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  imusgf_pkg::lane_ctl_t                ctl,
	input  logic signed [imusgf_pkg::RawW:0]     raw_in,
	input  logic signed [imusgf_pkg::OffW-1:0]   offset,
	input  logic [imusgf_pkg::CoefW-1:0]         coeff,
	input  logic [imusgf_pkg::CoefW-1:0]         dead_zone,
	output logic signed [imusgf_pkg::RateW-1:0]  rate_out
);
	import imusgf_pkg::*;

	logic signed [GyroProdW-1:0] prod_s1;
	logic signed [RateW-1:0]     x_s2;
	logic signed [LpProdW-1:0]   p1_s3;
	logic signed [RateW-1:0]     y1_s4;
	logic signed [LpProdW-1:0]   p2_s5;
	logic signed [RateW-1:0]     first_q;
	logic signed [RateW-1:0]     second_q;

	logic signed [RateW:0]       off_sum;
	logic signed [RateW-1:0]     x_sat;
	logic signed [LpProdW-1:0]   coeff_ext;
	logic signed [RateW:0]       diff1;
	logic signed [RateW:0]       diff2;
	logic signed [RateW+1:0]     y1_sum;
	logic signed [RateW+1:0]     y2_sum;
	logic signed [RateW-1:0]     y2;
	logic [RateW:0]              y2_mag;

	// Scale, add offset and clamp
	assign off_sum = {prod_s1[GyroProdW-1], prod_s1[GyroProdW-1:6]}
		+ {{(RateW+1-OffW){offset[OffW-1]}}, offset};
	assign x_sat = sat_rate(off_sum);

	// y = x + a*(last - x) >> 16, one multiplier per stage
	assign coeff_ext = {{(LpProdW-CoefW){1'b0}}, coeff};
	assign diff1  = {first_q[RateW-1], first_q} - {x_s2[RateW-1], x_s2};
	assign y1_sum = {{2{x_s2[RateW-1]}}, x_s2} + p1_s3[LpProdW-1:16];
	assign diff2  = {second_q[RateW-1], second_q} - {y1_s4[RateW-1], y1_s4};
	assign y2_sum = {{2{y1_s4[RateW-1]}}, y1_s4} + p2_s5[LpProdW-1:16];
	assign y2     = y2_sum[RateW-1:0];

	// Deadband on the reported value only
	assign y2_mag   = y2[RateW-1] ? -{y2[RateW-1], y2} : {1'b0, y2};
	assign rate_out = (y2_mag < {{(RateW+1-CoefW){1'b0}}, dead_zone}) ? '0 : y2;

	// Datapath steps
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			prod_s1 <= {{(GyroProdW-RawW-1){raw_in[RawW]}}, raw_in} * GyroGain;
		end
		if (ctl.scale) begin
			x_s2 <= x_sat;
		end
		if (ctl.mul1) begin
			p1_s3 <= coeff_ext * {{(LpProdW-RateW-1){diff1[RateW]}}, diff1};
		end
		if (ctl.add1) begin
			y1_s4 <= y1_sum[RateW-1:0];
		end
		if (ctl.mul2) begin
			p2_s5 <= coeff_ext * {{(LpProdW-RateW-1){diff2[RateW]}}, diff2};
		end
	end

	// Filter state: preload on the first item, then advance per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			second_q <= '0;
		end else begin
			if (ctl.scale && ctl.preload) begin
				first_q  <= x_sat;
				second_q <= x_sat;
			end
			if (ctl.add1) begin
				first_q <= y1_sum[RateW-1:0];
			end
			if (ctl.done) begin
				second_q <= y2;
			end
		end
	end

endmodule

[design/imu_sample_scale_and_gyro_filter_unit.sv]
// Top level: IMU sample scaling with a two-stage gyro low-pass and deadband.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid, in_stall, raw sample fields  | sample in
//  out     | out_valid, out_stall, scaled fields    | result out
//  cfg     | cfg_valid, cfg_ready, cfg_index/data   | register write
//
// Each item steps through the sequencer states SCALE, MUL1, ADD1, MUL2 and
// DONE, set by the chained filter steps in each gyro lane (scale, multiply,
// add, multiply, add). A new item is accepted in the cycle its predecessor
// is written to the output register, so items never overlap in the lanes.
// Reset clears the sequencer, the output valid, the filter state and the
// primed flag; registers take their defaults. A stalled output holds the
// finished item; the lanes wait in the last step until it is taken.
`timescale 1ns / 1ps
module imu_sample_scale_and_gyro_filter_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [imusgf_pkg::RawW-1:0]    accel_x_raw,
	input  logic signed [imusgf_pkg::RawW-1:0]    accel_y_raw,
	input  logic signed [imusgf_pkg::RawW-1:0]    accel_z_raw,
	input  logic signed [imusgf_pkg::RawW-1:0]    temp_raw,
	input  logic signed [imusgf_pkg::RawW-1:0]    gyro_x_raw,
	input  logic signed [imusgf_pkg::RawW-1:0]    gyro_y_raw,
	input  logic signed [imusgf_pkg::RawW-1:0]    gyro_z_raw,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [imusgf_pkg::AccelW-1:0]  accel_x,
	output logic signed [imusgf_pkg::AccelW-1:0]  accel_y,
	output logic signed [imusgf_pkg::AccelW-1:0]  accel_z,
	output logic signed [imusgf_pkg::RawW-1:0]    temp_out,
	output logic signed [imusgf_pkg::RateW-1:0]   rate_x,
	output logic signed [imusgf_pkg::RateW-1:0]   rate_y,
	output logic signed [imusgf_pkg::RateW-1:0]   rate_z,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [imusgf_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [imusgf_pkg::CoefW-1:0]          cfg_data
);
	import imusgf_pkg::*;

	`include "imu_sample_scale_and_gyro_filter_unit_assert.svh"

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCALE = 6'b000010,
		ST_MUL1  = 6'b000100,
		ST_ADD1  = 6'b001000,
		ST_MUL2  = 6'b010000,
		ST_DONE  = 6'b100000
	} seq_state_t;

	seq_state_t state_q, state_d;

	logic [CoefW-1:0]       coeff_q;
	logic [CoefW-1:0]       dead_q;
	logic signed [OffW-1:0] off_x_q;
	logic signed [OffW-1:0] off_y_q;
	logic signed [OffW-1:0] off_z_q;
	logic                   primed_q;
	logic                   out_valid_q;
	logic signed [RawW-1:0] temp_q;

	logic      in_acc;
	logic      out_free;
	logic      done_fire;
	lane_ctl_t ctl;

	logic signed [AccelW-1:0] ax_lane, ay_lane, az_lane;
	logic signed [RateW-1:0]  rx_lane, ry_lane, rz_lane;

	logic signed [AccelW-1:0] accel_x_q, accel_y_q, accel_z_q;
	logic signed [RawW-1:0]   temp_out_q;
	logic signed [RateW-1:0]  rate_x_q, rate_y_q, rate_z_q;

	// Handshake
	assign out_free  = !out_valid_q || !out_stall;
	assign done_fire = (state_q == ST_DONE) && out_free;
	assign in_stall  = !((state_q == ST_IDLE) || done_fire);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Lane strobes
	always_comb begin
		ctl.load    = in_acc;
		ctl.scale   = (state_q == ST_SCALE);
		ctl.preload = !primed_q;
		ctl.mul1    = (state_q == ST_MUL1);
		ctl.add1    = (state_q == ST_ADD1);
		ctl.mul2    = (state_q == ST_MUL2);
		ctl.done    = done_fire;
	end

	// Advance the sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_acc) state_d = ST_SCALE;
			ST_SCALE: state_d = ST_MUL1;
			ST_MUL1:  state_d = ST_ADD1;
			ST_ADD1:  state_d = ST_MUL2;
			ST_MUL2:  state_d = ST_DONE;
			ST_DONE: begin
				if (done_fire) state_d = in_acc ? ST_SCALE : ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			primed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.scale) begin
				primed_q <= 1'b1;
			end
			if (done_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Configuration registers; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= CoeffReset;
			dead_q  <= DeadReset;
			off_x_q <= OffsetXReset;
			off_y_q <= OffsetYReset;
			off_z_q <= OffsetZReset;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FILTER_COEFF: coeff_q <= cfg_data;
				REG_DEAD_ZONE:    dead_q  <= cfg_data;
				REG_OFFSET_X:     off_x_q <= cfg_data[OffW-1:0];
				REG_OFFSET_Y:     off_y_q <= cfg_data[OffW-1:0];
				REG_OFFSET_Z:     off_z_q <= cfg_data[OffW-1:0];
				default: ;
			endcase
		end
	end

	// Hold temperature for the life of the item
	always_ff @(posedge clk) begin
		if (in_acc) begin
			temp_q <= temp_raw;
		end
	end

	// Accel lanes; X negated
	imusgf_accel_lane u_accel_x (
		.clk(clk), .ctl(ctl), .raw_in(-ext_raw(accel_x_raw)), .accel_out(ax_lane)
	);
	imusgf_accel_lane u_accel_y (
		.clk(clk), .ctl(ctl), .raw_in(ext_raw(accel_y_raw)), .accel_out(ay_lane)
	);
	imusgf_accel_lane u_accel_z (
		.clk(clk), .ctl(ctl), .raw_in(ext_raw(accel_z_raw)), .accel_out(az_lane)
	);

	// Gyro lanes; Y negated
	imusgf_gyro_lane u_gyro_x (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .raw_in(ext_raw(gyro_x_raw)),
		.offset(off_x_q), .coeff(coeff_q), .dead_zone(dead_q), .rate_out(rx_lane)
	);
	imusgf_gyro_lane u_gyro_y (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .raw_in(-ext_raw(gyro_y_raw)),
		.offset(off_y_q), .coeff(coeff_q), .dead_zone(dead_q), .rate_out(ry_lane)
	);
	imusgf_gyro_lane u_gyro_z (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .raw_in(ext_raw(gyro_z_raw)),
		.offset(off_z_q), .coeff(coeff_q), .dead_zone(dead_q), .rate_out(rz_lane)
	);

	// Merge lane results into the output register
	always_ff @(posedge clk) begin
		if (done_fire) begin
			accel_x_q  <= ax_lane;
			accel_y_q  <= ay_lane;
			accel_z_q  <= az_lane;
			temp_out_q <= temp_q;
			rate_x_q   <= rx_lane;
			rate_y_q   <= ry_lane;
			rate_z_q   <= rz_lane;
		end
	end

	assign out_valid = out_valid_q;
	assign accel_x   = accel_x_q;
	assign accel_y   = accel_y_q;
	assign accel_z   = accel_z_q;
	assign temp_out  = temp_out_q;
	assign rate_x    = rate_x_q;
	assign rate_y    = rate_y_q;
	assign rate_z    = rate_z_q;

	`IMUSGF_ASSERT_NEXT(a_accept_starts, in_acc, state_q == ST_SCALE,
		"accepted item did not start the scale step")
	`IMUSGF_ASSERT_NOW(a_accept_when_free, in_acc, (state_q == ST_IDLE) || done_fire,
		"item accepted while lanes busy")
	`IMUSGF_ASSERT_NEXT(a_done_shows, done_fire, out_valid_q,
		"finished item not presented")
	`IMUSGF_ASSERT_NEXT(a_primed_holds, primed_q, primed_q,
		"filter primed flag dropped")

endmodule

[test/imu_sample_scale_and_gyro_filter_unit_test.sv]
// Self-checking testbench for the IMU scale and gyro filter unit.
`timescale 1ns / 1ps
module imu_sample_scale_and_gyro_filter_unit_test;
	import imusgf_pkg::*;

	localparam int      ItemsPerPhase = 118;
	localparam int      PhaseCount    = 8;
	localparam int      IdlePct       = 19;
	localparam int      QuietLimit    = 2000;
	localparam int      TailCycles    = 12;
	localparam longint  AccelScale    = 10035;
	localparam int      AccelShift    = 16;
	localparam longint  GyroScale     = 999;
	localparam int      GyroShift     = 6;
	localparam longint  CoefUnity     = 65536;
	localparam int      CoefShift     = 16;
	localparam longint  RateHi        = 524287;
	localparam longint  RateLo        = -524288;
	localparam int      OffsetHi      = 2560;
	localparam logic [CfgIdxW-1:0] RegUnusedLo = 3'd5;
	localparam logic [CfgIdxW-1:0] RegUnusedHi = 3'd7;

	typedef struct {
		logic signed [RawW-1:0] accel_x_raw;
		logic signed [RawW-1:0] accel_y_raw;
		logic signed [RawW-1:0] accel_z_raw;
		logic signed [RawW-1:0] temp_raw;
		logic signed [RawW-1:0] gyro_x_raw;
		logic signed [RawW-1:0] gyro_y_raw;
		logic signed [RawW-1:0] gyro_z_raw;
	} imu_sample_t;

	typedef struct {
		logic signed [AccelW-1:0] accel_x;
		logic signed [AccelW-1:0] accel_y;
		logic signed [AccelW-1:0] accel_z;
		logic signed [RawW-1:0]   temp_out;
		logic signed [RateW-1:0]  rate_x;
		logic signed [RateW-1:0]  rate_y;
		logic signed [RateW-1:0]  rate_z;
	} imu_result_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [RawW-1:0] accel_x_raw, accel_y_raw, accel_z_raw, temp_raw;
	logic signed [RawW-1:0] gyro_x_raw, gyro_y_raw, gyro_z_raw;
	logic out_valid;
	logic out_stall;
	logic signed [AccelW-1:0] accel_x, accel_y, accel_z;
	logic signed [RawW-1:0]   temp_out;
	logic signed [RateW-1:0]  rate_x, rate_y, rate_z;
	logic cfg_valid;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CoefW-1:0]   cfg_data;

	// Predictor copy of the registers and filter state
	logic [CoefW-1:0]        coeff_m;
	logic [CoefW-1:0]        dead_m;
	logic signed [OffW-1:0]  ofs_m [3];
	logic signed [RateW-1:0] stage1_m [3];
	logic signed [RateW-1:0] stage2_m [3];
	bit                      primed_m;

	imu_result_t expected_scaled_q [$];
	int          mismatches;
	int          quiet_cycles;
	bit          steady;
	int          walk [3];

	imu_sample_scale_and_gyro_filter_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.accel_x_raw (accel_x_raw),
		.accel_y_raw (accel_y_raw),
		.accel_z_raw (accel_z_raw),
		.temp_raw    (temp_raw),
		.gyro_x_raw  (gyro_x_raw),
		.gyro_y_raw  (gyro_y_raw),
		.gyro_z_raw  (gyro_z_raw),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.accel_x     (accel_x),
		.accel_y     (accel_y),
		.accel_z     (accel_z),
		.temp_out    (temp_out),
		.rate_x      (rate_x),
		.rate_y      (rate_y),
		.rate_z      (rate_z),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bit take_break();
		return !steady && ($urandom_range(99) < IdlePct);
	endfunction

	function automatic longint clamp_rate(input longint v);
		if (v > RateHi)
			return RateHi;
		if (v < RateLo)
			return RateLo;
		return v;
	endfunction

	// One first-order stage: weight a on the previous output
	function automatic longint lowpass(input longint last, input longint x);
		longint a;
		a = longint'(coeff_m);
		return (a * last + (CoefUnity - a) * x) >>> CoefShift;
	endfunction

	// Scale one sample and advance both filter stages of every gyro axis
	function automatic imu_result_t scale_and_filter(input imu_sample_t s);
		imu_result_t r;
		longint      rate [3];
		longint      shown [3];
		longint      s1, s2, mag;
		int          i;
		r.accel_x  = AccelW'((-longint'(s.accel_x_raw) * AccelScale) >>> AccelShift);
		r.accel_y  = AccelW'((longint'(s.accel_y_raw) * AccelScale) >>> AccelShift);
		r.accel_z  = AccelW'((longint'(s.accel_z_raw) * AccelScale) >>> AccelShift);
		r.temp_out = s.temp_raw;
		rate[0] = ((longint'(s.gyro_x_raw) * GyroScale) >>> GyroShift) + longint'(ofs_m[0]);
		rate[1] = ((-longint'(s.gyro_y_raw) * GyroScale) >>> GyroShift) + longint'(ofs_m[1]);
		rate[2] = ((longint'(s.gyro_z_raw) * GyroScale) >>> GyroShift) + longint'(ofs_m[2]);
		for (i = 0; i < 3; i++)
			rate[i] = clamp_rate(rate[i]);
		// preload both stages on the first sample after reset
		if (!primed_m) begin
			for (i = 0; i < 3; i++) begin
				stage1_m[i] = RateW'(rate[i]);
				stage2_m[i] = RateW'(rate[i]);
			end
			primed_m = 1'b1;
		end
		for (i = 0; i < 3; i++) begin
			s1 = lowpass(stage1_m[i], rate[i]);
			s2 = lowpass(stage2_m[i], s1);
			stage1_m[i] = RateW'(s1);
			stage2_m[i] = RateW'(s2);
			// deadband hides small rates but leaves the state alone
			mag = (s2 < 0) ? -s2 : s2;
			shown[i] = (mag < longint'(dead_m)) ? 0 : s2;
		end
		r.rate_x = RateW'(shown[0]);
		r.rate_y = RateW'(shown[1]);
		r.rate_z = RateW'(shown[2]);
		return r;
	endfunction

	function automatic imu_sample_t mk(input int ax, input int ay, input int az, input int t,
			input int gx, input int gy, input int gz);
		imu_sample_t s;
		s.accel_x_raw = RawW'(ax);
		s.accel_y_raw = RawW'(ay);
		s.accel_z_raw = RawW'(az);
		s.temp_raw    = RawW'(t);
		s.gyro_x_raw  = RawW'(gx);
		s.gyro_y_raw  = RawW'(gy);
		s.gyro_z_raw  = RawW'(gz);
		return s;
	endfunction

	function automatic int rand_offset();
		return int'($urandom_range(2 * OffsetHi)) - OffsetHi;
	endfunction

	// Offer one item, hold it until taken, then predict its result
	task automatic send_sample(input imu_sample_t s);
		while (take_break()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		accel_x_raw <= s.accel_x_raw;
		accel_y_raw <= s.accel_y_raw;
		accel_z_raw <= s.accel_z_raw;
		temp_raw    <= s.temp_raw;
		gyro_x_raw  <= s.gyro_x_raw;
		gyro_y_raw  <= s.gyro_y_raw;
		gyro_z_raw  <= s.gyro_z_raw;
		do @(posedge clk); while (in_stall);
		expected_scaled_q.push_back(scale_and_filter(s));
	endtask

	// Drop valid and wait for every outstanding result
	task automatic wait_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_scaled_q.size() != 0);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CoefW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_FILTER_COEFF: coeff_m  = data;
			REG_DEAD_ZONE:    dead_m   = data;
			REG_OFFSET_X:     ofs_m[0] = OffW'(data);
			REG_OFFSET_Y:     ofs_m[1] = OffW'(data);
			REG_OFFSET_Z:     ofs_m[2] = OffW'(data);
			default:          ;
		endcase
	endtask

	// Write all registers while idle, plus a write to an unmapped index
	task automatic set_config(input logic [CoefW-1:0] coeff, input logic [CoefW-1:0] dead,
			input int ox, input int oy, input int oz);
		wait_drain();
		write_reg(REG_FILTER_COEFF, coeff);
		write_reg(REG_DEAD_ZONE, dead);
		write_reg(REG_OFFSET_X, CoefW'(ox));
		write_reg(REG_OFFSET_Y, CoefW'(oy));
		write_reg(REG_OFFSET_Z, CoefW'(oz));
		write_reg(CfgIdxW'($urandom_range(RegUnusedLo, RegUnusedHi)), CoefW'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// First items after reset run on register defaults and preload the filter
	task automatic test_first_sample();
		send_sample(mk(100, -100, 16384, 1234, 500, -500, 20));
		send_sample(mk(-2000, 300, -16384, -1234, -800, 1200, -40));
		send_sample(mk(0, 0, 0, 0, 0, 0, 0));
	endtask

	// Field extremes with a transparent filter and extreme offsets
	task automatic test_field_extremes();
		set_config(16'd0, 16'd0, OffsetHi, -OffsetHi, OffsetHi);
		send_sample(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767));
		send_sample(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
		send_sample(mk(0, 0, 0, 0, 0, 0, 0));
		send_sample(mk(-1, -1, -1, -1, -1, -1, -1));
		send_sample(mk(1, 1, 1, 1, 1, 1, 1));
		send_sample(mk(16'h5555, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 16'h5555));
		send_sample(mk(16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA));
		set_config(16'd0, 16'd0, -OffsetHi, OffsetHi, -OffsetHi);
		send_sample(mk(-32768, 32767, -32768, 0, 32767, -32768, 32767));
		send_sample(mk(32767, -32768, 32767, 0, -32768, 32767, -32768));
	endtask

	// Rates right at and just under the threshold, then the widest threshold
	task automatic test_deadband();
		set_config(16'd0, 16'd999, 0, 0, 0);
		send_sample(mk(0, 0, 0, 0, 64, -63, 63));
		send_sample(mk(0, 0, 0, 0, -64, 64, -63));
		set_config(16'd0, 16'hFFFF, 0, 0, 0);
		send_sample(mk(0, 0, 0, 0, 32767, 4000, -32768));
	endtask

	// Heaviest smoothing: output barely follows a full-swing input
	task automatic test_coeff_extremes();
		set_config(16'hFFFF, 16'd0, 0, 0, 0);
		send_sample(mk(0, 0, 0, 0, 32767, -32768, 32767));
		send_sample(mk(0, 0, 0, 0, -32768, 32767, -32768));
		send_sample(mk(0, 0, 0, 0, 32767, -32768, 32767));
	endtask

	// Random phases: slow gyro drifts, near-zero rates and full-range noise
	task automatic test_random();
		imu_sample_t s;
		int          phase, n, i, pick, v;
		for (phase = 0; phase < PhaseCount; phase++) begin
			case (phase)
				0:       set_config(16'hFFFF, 16'd0, OffsetHi, -OffsetHi, 0);
				1:       set_config(16'd0, 16'hFFFF, -OffsetHi, OffsetHi, -OffsetHi);
				default: set_config(CoefW'($urandom), CoefW'($urandom_range(2000)),
						rand_offset(), rand_offset(), rand_offset());
			endcase
			steady = (phase == 3);
			for (i = 0; i < 3; i++)
				walk[i] = int'($urandom_range(65535)) - 32768;
			for (n = 0; n < ItemsPerPhase; n++) begin
				s = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
				pick = $urandom_range(3);
				if (pick < 2) begin
					for (i = 0; i < 3; i++) begin
						v = walk[i] + int'($urandom_range(512)) - 256;
						walk[i] = (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
					end
					s.gyro_x_raw = RawW'(walk[0]);
					s.gyro_y_raw = RawW'(walk[1]);
					s.gyro_z_raw = RawW'(walk[2]);
				end else if (pick == 2) begin
					s.gyro_x_raw = RawW'(int'($urandom_range(400)) - 200);
					s.gyro_y_raw = RawW'(int'($urandom_range(400)) - 200);
					s.gyro_z_raw = RawW'(int'($urandom_range(400)) - 200);
				end
				send_sample(s);
			end
			steady = 1'b0;
		end
	endtask

	task automatic check_field(input string name, input longint exp_v, input longint act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// Compare every taken result with the oldest prediction
	always @(posedge clk) begin
		imu_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_scaled_q.size() == 0) begin
				$display("%0t: result with no item outstanding", $time);
				mismatches++;
			end else begin
				e = expected_scaled_q.pop_front();
				check_field("accel_x", e.accel_x, accel_x);
				check_field("accel_y", e.accel_y, accel_y);
				check_field("accel_z", e.accel_z, accel_z);
				check_field("temp_out", e.temp_out, temp_out);
				check_field("rate_x", e.rate_x, rate_x);
				check_field("rate_y", e.rate_y, rate_y);
				check_field("rate_z", e.rate_z, rate_z);
			end
		end
	end

	// Random output back-pressure, off during steady stretches
	always @(posedge clk)
		out_stall <= take_break();

	// End the run if no channel moves an item for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QuietLimit) begin
			$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
			$display("FAIL imu_sample_scale_and_gyro_filter_unit");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		mismatches  = 0;
		steady      = 1'b0;
		coeff_m     = CoeffReset;
		dead_m      = DeadReset;
		ofs_m[0]    = OffsetXReset;
		ofs_m[1]    = OffsetYReset;
		ofs_m[2]    = OffsetZReset;
		primed_m    = 1'b0;
		for (int i = 0; i < 3; i++) begin
			stage1_m[i] = '0;
			stage2_m[i] = '0;
		end
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		accel_x_raw <= '0;
		accel_y_raw <= '0;
		accel_z_raw <= '0;
		temp_raw    <= '0;
		gyro_x_raw  <= '0;
		gyro_y_raw  <= '0;
		gyro_z_raw  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_sample();
		test_field_extremes();
		test_deadband();
		test_coeff_extremes();
		test_random();

		wait_drain();
		repeat (TailCycles) @(posedge clk);
		if (mismatches == 0)
			$display("PASS imu_sample_scale_and_gyro_filter_unit");
		else
			$display("FAIL imu_sample_scale_and_gyro_filter_unit");
		$finish;
	end

endmodule
